[src/ocrp_pkg.sv]
// ----------------------------------------------------------------------------
// ocrp_pkg
// Shared types and constants of the oldest complete run planner.
// ----------------------------------------------------------------------------
`default_nettype none

package ocrp_pkg;

  localparam int ID_W         = 32;
  localparam int REASON_W     = 8;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int CFG_AW       = 1;
  localparam int CFG_DW       = 8;
  localparam int RESULT_LIMIT = 32;
  localparam int CHAIN_AW     = 5;
  localparam int CHAIN_CW     = 6;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 2'd0,
    OP_ADD_SEG   = 2'd1,
    OP_ADD_GUARD = 2'd2,
    OP_PLAN      = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND   = 2'd0,
    ST_INVALID = 2'd1,
    ST_NONE    = 2'd2
  } status_t;

  localparam logic [CFG_AW-1:0] CFG_IDX_INTERRUPTED = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_IDX_LAST_VALID  = 1'b1;

  localparam logic [REASON_W-1:0] CFG_RST_INTERRUPTED = 8'd1;
  localparam logic [REASON_W-1:0] CFG_RST_LAST_VALID  = 8'd2;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [ID_W-1:0]     parent;
    logic [REASON_W-1:0] reason;
  } seg_entry_t;

  localparam int SEG_W = $bits(seg_entry_t);

  typedef struct packed {
    logic [REASON_W-1:0] interrupted_code;
    logic [REASON_W-1:0] last_valid_reason;
  } cfg_t;

endpackage

`default_nettype wire

[src/ocrp_if.sv]
// ----------------------------------------------------------------------------
// ocrp_if
// Valid/ready channels carrying request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface ocrp_in_if;
  import ocrp_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [ID_W-1:0]     segment_id;
  logic [ID_W-1:0]     parent_id;
  logic [REASON_W-1:0] finish_reason;
  logic [ID_W-1:0]     protected_id;

  modport source (output valid, op, segment_id, parent_id, finish_reason, protected_id,
                  input ready);
  modport sink   (input valid, op, segment_id, parent_id, finish_reason, protected_id,
                  output ready);
endinterface

interface ocrp_out_if;
  import ocrp_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     root_id;
  logic [ID_W-1:0]     session_id;
  logic                last;

  modport source (output valid, status, root_id, session_id, last, input ready);
  modport sink   (input valid, status, root_id, session_id, last, output ready);
endinterface

`default_nettype wire

[src/ocrp_ram.sv]
// ----------------------------------------------------------------------------
// ocrp_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ocrp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/ocrp_seq.sv]
// ----------------------------------------------------------------------------
// ocrp_seq
// Sequencer: catalog loads, validation scans, chain walks and result output.
// ----------------------------------------------------------------------------
`default_nettype none

module ocrp_seq #(
  parameter int MAX_SEGMENTS  = 32,
  parameter int MAX_PROTECTED = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ocrp_in_if.sink                    in_ch,
  ocrp_out_if.source                 out_ch,
  input  wire ocrp_pkg::cfg_t        cfg,
  output logic                       seg_we,
  output logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] seg_waddr,
  output ocrp_pkg::seg_entry_t       seg_wdata,
  output logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] seg_raddr,
  input  wire ocrp_pkg::seg_entry_t  seg_rdata,
  output logic                       grd_we,
  output logic [((MAX_PROTECTED > 1) ? $clog2(MAX_PROTECTED) : 1)-1:0] grd_waddr,
  output logic [ocrp_pkg::ID_W-1:0]  grd_wdata,
  output logic [((MAX_PROTECTED > 1) ? $clog2(MAX_PROTECTED) : 1)-1:0] grd_raddr,
  input  wire logic [ocrp_pkg::ID_W-1:0] grd_rdata,
  output logic                       chn_we,
  output logic [ocrp_pkg::CHAIN_AW-1:0] chn_waddr,
  output logic [ocrp_pkg::ID_W-1:0]  chn_wdata,
  output logic [ocrp_pkg::CHAIN_AW-1:0] chn_raddr,
  input  wire logic [ocrp_pkg::ID_W-1:0] chn_rdata
);
  import ocrp_pkg::*;

  localparam int SIW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SCW = $clog2(MAX_SEGMENTS + 1);
  localparam int GIW = (MAX_PROTECTED > 1) ? $clog2(MAX_PROTECTED) : 1;
  localparam int GCW = $clog2(MAX_PROTECTED + 1);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_V_RDI = 18'h00002,
    S_V_LDI = 18'h00004,
    S_V_RDJ = 18'h00008,
    S_V_CHK = 18'h00010,
    S_V_END = 18'h00020,
    S_R_RDI = 18'h00040,
    S_R_LDI = 18'h00080,
    S_G_RD  = 18'h00100,
    S_G_CHK = 18'h00200,
    S_C_RD  = 18'h00400,
    S_C_CHK = 18'h00800,
    S_R_NXT = 18'h01000,
    S_E_RD  = 18'h02000,
    S_E_CHK = 18'h04000,
    S_O_RD  = 18'h08000,
    S_O_OUT = 18'h10000,
    S_FAIL  = 18'h20000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SCW-1:0]        seg_cnt_r, seg_cnt_nxt;
  logic [GCW-1:0]        grd_cnt_r, grd_cnt_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [SCW-1:0]        i_r, i_nxt;
  logic [SCW-1:0]        j_r, j_nxt;
  logic [GCW-1:0]        k_r, k_nxt;
  logic [ID_W-1:0]       a_id_r, a_id_nxt;
  logic [ID_W-1:0]       a_par_r, a_par_nxt;
  logic [ID_W-1:0]       root_id_r, root_id_nxt;
  logic [ID_W-1:0]       best_id_r, best_id_nxt;
  logic                  fnd_r, fnd_nxt;
  logic                  hit_r, hit_nxt;
  logic                  kid_r, kid_nxt;
  logic                  bad_r, bad_nxt;
  logic [CHAIN_CW-1:0]   n_r, n_nxt;
  logic [CHAIN_AW-1:0]   e_r, e_nxt;
  status_t               fail_r, fail_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [ID_W-1:0]       out_root_r, out_root_nxt;
  logic [ID_W-1:0]       out_sess_r, out_sess_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  can_load;
  logic                  j_end, i_end, k_end;

  assign can_load = !out_valid_r || out_ch.ready;
  assign j_end    = (j_r + SCW'(1)) == seg_cnt_r;
  assign i_end    = (i_r + SCW'(1)) == seg_cnt_r;
  assign k_end    = (k_r + GCW'(1)) == grd_cnt_r;

  assign in_ch.ready = (state_r == S_IDLE);

  assign seg_waddr = seg_cnt_r[SIW-1:0];
  assign seg_wdata = '{id: in_ch.segment_id, parent: in_ch.parent_id,
                       reason: in_ch.finish_reason};
  assign grd_waddr = grd_cnt_r[GIW-1:0];
  assign grd_wdata = in_ch.protected_id;
  assign grd_raddr = k_r[GIW-1:0];
  assign chn_raddr = e_r;

  always_comb begin
    state_nxt      = state_r;
    seg_cnt_nxt    = seg_cnt_r;
    grd_cnt_nxt    = grd_cnt_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    a_id_nxt       = a_id_r;
    a_par_nxt      = a_par_r;
    root_id_nxt    = root_id_r;
    best_id_nxt    = best_id_r;
    fnd_nxt        = fnd_r;
    hit_nxt        = hit_r;
    kid_nxt        = kid_r;
    bad_nxt        = bad_r;
    n_nxt          = n_r;
    e_nxt          = e_r;
    fail_nxt       = fail_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_root_nxt   = out_root_r;
    out_sess_nxt   = out_sess_r;
    out_last_nxt   = out_last_r;
    seg_we         = 1'b0;
    grd_we         = 1'b0;
    seg_raddr      = i_r[SIW-1:0];
    chn_we         = 1'b0;
    chn_waddr      = n_r[CHAIN_AW-1:0];
    chn_wdata      = seg_rdata.id;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (op_t'(in_ch.op))
            OP_CLEAR: begin
              seg_cnt_nxt = '0;
              grd_cnt_nxt = '0;
              ovf_nxt     = 1'b0;
            end
            OP_ADD_SEG: begin
              if (seg_cnt_r < SCW'(MAX_SEGMENTS)) begin
                seg_we      = 1'b1;
                seg_cnt_nxt = seg_cnt_r + SCW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            OP_ADD_GUARD: begin
              if (grd_cnt_r < GCW'(MAX_PROTECTED)) begin
                grd_we      = 1'b1;
                grd_cnt_nxt = grd_cnt_r + GCW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            default: begin
              if (ovf_r || seg_cnt_r == '0) begin
                fail_nxt  = ST_INVALID;
                state_nxt = S_FAIL;
              end else begin
                i_nxt     = '0;
                state_nxt = S_V_RDI;
              end
            end
          endcase
        end
      end
      S_V_RDI: state_nxt = S_V_LDI;
      S_V_LDI: begin
        if (seg_rdata.id == '0 || seg_rdata.reason > cfg.last_valid_reason) begin
          fail_nxt  = ST_INVALID;
          state_nxt = S_FAIL;
        end else begin
          a_id_nxt  = seg_rdata.id;
          a_par_nxt = seg_rdata.parent;
          j_nxt     = '0;
          hit_nxt   = 1'b0;
          kid_nxt   = 1'b0;
          state_nxt = S_V_RDJ;
        end
      end
      S_V_RDJ: begin
        seg_raddr = j_r[SIW-1:0];
        state_nxt = S_V_CHK;
      end
      S_V_CHK: begin
        if ((j_r > i_r && seg_rdata.id == a_id_r) ||
            (seg_rdata.parent == a_id_r && kid_r)) begin
          fail_nxt  = ST_INVALID;
          state_nxt = S_FAIL;
        end else begin
          if (seg_rdata.id == a_par_r) hit_nxt = 1'b1;
          if (seg_rdata.parent == a_id_r) kid_nxt = 1'b1;
          if (j_end) begin
            state_nxt = S_V_END;
          end else begin
            j_nxt     = j_r + SCW'(1);
            state_nxt = S_V_RDJ;
          end
        end
      end
      S_V_END: begin
        if (a_par_r != '0 && (a_par_r >= a_id_r || !hit_r)) begin
          fail_nxt  = ST_INVALID;
          state_nxt = S_FAIL;
        end else if (i_end) begin
          i_nxt     = '0;
          fnd_nxt   = 1'b0;
          state_nxt = S_R_RDI;
        end else begin
          i_nxt     = i_r + SCW'(1);
          state_nxt = S_V_RDI;
        end
      end
      S_R_RDI: state_nxt = S_R_LDI;
      S_R_LDI: begin
        if (seg_rdata.parent != '0) begin
          state_nxt = S_R_NXT;
        end else begin
          a_id_nxt    = seg_rdata.id;
          root_id_nxt = seg_rdata.id;
          bad_nxt     = (seg_rdata.reason == cfg.interrupted_code);
          k_nxt       = '0;
          j_nxt       = '0;
          state_nxt   = (grd_cnt_r == '0) ? S_C_RD : S_G_RD;
        end
      end
      S_G_RD: state_nxt = S_G_CHK;
      S_G_CHK: begin
        if (grd_rdata == a_id_r) bad_nxt = 1'b1;
        if (k_end) begin
          j_nxt     = '0;
          state_nxt = S_C_RD;
        end else begin
          k_nxt     = k_r + GCW'(1);
          state_nxt = S_G_RD;
        end
      end
      S_C_RD: begin
        seg_raddr = j_r[SIW-1:0];
        state_nxt = S_C_CHK;
      end
      S_C_CHK: begin
        if (seg_rdata.parent == a_id_r) begin
          a_id_nxt  = seg_rdata.id;
          bad_nxt   = bad_r || (seg_rdata.reason == cfg.interrupted_code);
          k_nxt     = '0;
          j_nxt     = '0;
          state_nxt = (grd_cnt_r == '0) ? S_C_RD : S_G_RD;
        end else if (j_end) begin
          if (!bad_r && (!fnd_r || root_id_r < best_id_r)) begin
            best_id_nxt = root_id_r;
            fnd_nxt     = 1'b1;
          end
          state_nxt = S_R_NXT;
        end else begin
          j_nxt     = j_r + SCW'(1);
          state_nxt = S_C_RD;
        end
      end
      S_R_NXT: begin
        if (!i_end) begin
          i_nxt     = i_r + SCW'(1);
          state_nxt = S_R_RDI;
        end else if (!fnd_r) begin
          fail_nxt  = ST_NONE;
          state_nxt = S_FAIL;
        end else begin
          chn_we    = 1'b1;
          chn_waddr = '0;
          chn_wdata = best_id_r;
          n_nxt     = CHAIN_CW'(1);
          a_id_nxt  = best_id_r;
          j_nxt     = '0;
          state_nxt = S_E_RD;
        end
      end
      S_E_RD: begin
        seg_raddr = j_r[SIW-1:0];
        state_nxt = S_E_CHK;
      end
      S_E_CHK: begin
        if (seg_rdata.parent == a_id_r) begin
          if (n_r == CHAIN_CW'(RESULT_LIMIT)) begin
            fail_nxt  = ST_INVALID;
            state_nxt = S_FAIL;
          end else begin
            chn_we    = 1'b1;
            n_nxt     = n_r + CHAIN_CW'(1);
            a_id_nxt  = seg_rdata.id;
            j_nxt     = '0;
            state_nxt = S_E_RD;
          end
        end else if (j_end) begin
          e_nxt     = CHAIN_AW'(n_r - CHAIN_CW'(1));
          state_nxt = S_O_RD;
        end else begin
          j_nxt     = j_r + SCW'(1);
          state_nxt = S_E_RD;
        end
      end
      S_O_RD: state_nxt = S_O_OUT;
      S_O_OUT: begin
        if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FOUND;
          out_root_nxt   = best_id_r;
          out_sess_nxt   = chn_rdata;
          out_last_nxt   = (e_r == '0);
          if (e_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            e_nxt     = e_r - CHAIN_AW'(1);
            state_nxt = S_O_RD;
          end
        end
      end
      S_FAIL: begin
        if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fail_r;
          out_root_nxt   = '0;
          out_sess_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seg_cnt_r   <= '0;
      grd_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_cnt_r   <= seg_cnt_nxt;
      grd_cnt_r   <= grd_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    a_id_r       <= a_id_nxt;
    a_par_r      <= a_par_nxt;
    root_id_r    <= root_id_nxt;
    best_id_r    <= best_id_nxt;
    fnd_r        <= fnd_nxt;
    hit_r        <= hit_nxt;
    kid_r        <= kid_nxt;
    bad_r        <= bad_nxt;
    n_r          <= n_nxt;
    e_r          <= e_nxt;
    fail_r       <= fail_nxt;
    out_status_r <= out_status_nxt;
    out_root_r   <= out_root_nxt;
    out_sess_r   <= out_sess_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.root_id    = out_root_r;
  assign out_ch.session_id = out_sess_r;
  assign out_ch.last       = out_last_r;

endmodule

`default_nettype wire

[src/oldest_complete_run_planner.sv]
// ----------------------------------------------------------------------------
// oldest_complete_run_planner
// Segment catalog with a planner that selects the oldest complete run.
//
// in_ch carries request words: clear, add segment, add protected id, plan.
// Clear and add words are taken while idle, so loads stream at one per cycle.
// A plan word walks the segment RAM through a single read port: it first
// validates every segment, then walks the chain of each root and checks
// its segments against the protected ids, then fetches the chain of the
// chosen root and emits its words. in_ch.ready stays low from the plan
// word until its last result word is loaded.
// out_ch carries result words newest first, root last, last set on the
// final word; a failure gives a single status word. A registered output
// stage holds the word while out_ch.ready is low and the sequencer waits.
// Reset empties the catalog and the protected list, clears the overflow
// flag and loads the reset register values; RAM contents are not cleared.
// cfg_we writes cfg_wdata into register cfg_addr.
// ----------------------------------------------------------------------------
`default_nettype none

module oldest_complete_run_planner #(
  parameter int MAX_SEGMENTS  = 32,
  parameter int MAX_PROTECTED = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  ocrp_in_if.sink                            in_ch,
  ocrp_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [ocrp_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [ocrp_pkg::CFG_DW-1:0]   cfg_wdata
);
  import ocrp_pkg::*;

  localparam int SIW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int GIW = (MAX_PROTECTED > 1) ? $clog2(MAX_PROTECTED) : 1;

  cfg_t                cfg_r;
  logic                seg_we;
  logic [SIW-1:0]      seg_waddr;
  logic [SIW-1:0]      seg_raddr;
  seg_entry_t          seg_wdata;
  seg_entry_t          seg_rdata;
  logic                grd_we;
  logic [GIW-1:0]      grd_waddr;
  logic [GIW-1:0]      grd_raddr;
  logic [ID_W-1:0]     grd_wdata;
  logic [ID_W-1:0]     grd_rdata;
  logic                chn_we;
  logic [CHAIN_AW-1:0] chn_waddr;
  logic [CHAIN_AW-1:0] chn_raddr;
  logic [ID_W-1:0]     chn_wdata;
  logic [ID_W-1:0]     chn_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interrupted_code  <= CFG_RST_INTERRUPTED;
      cfg_r.last_valid_reason <= CFG_RST_LAST_VALID;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IDX_INTERRUPTED: cfg_r.interrupted_code  <= cfg_wdata;
        CFG_IDX_LAST_VALID:  cfg_r.last_valid_reason <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ocrp_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS), .AW(SIW)) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (seg_waddr),
    .wdata (seg_wdata),
    .raddr (seg_raddr),
    .rdata (seg_rdata)
  );

  ocrp_ram #(.WIDTH(ID_W), .DEPTH(MAX_PROTECTED), .AW(GIW)) u_grd_ram (
    .clk   (clk),
    .we    (grd_we),
    .waddr (grd_waddr),
    .wdata (grd_wdata),
    .raddr (grd_raddr),
    .rdata (grd_rdata)
  );

  ocrp_ram #(.WIDTH(ID_W), .DEPTH(RESULT_LIMIT), .AW(CHAIN_AW)) u_chn_ram (
    .clk   (clk),
    .we    (chn_we),
    .waddr (chn_waddr),
    .wdata (chn_wdata),
    .raddr (chn_raddr),
    .rdata (chn_rdata)
  );

  ocrp_seq #(.MAX_SEGMENTS(MAX_SEGMENTS), .MAX_PROTECTED(MAX_PROTECTED)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg       (cfg_r),
    .seg_we    (seg_we),
    .seg_waddr (seg_waddr),
    .seg_wdata (seg_wdata),
    .seg_raddr (seg_raddr),
    .seg_rdata (seg_rdata),
    .grd_we    (grd_we),
    .grd_waddr (grd_waddr),
    .grd_wdata (grd_wdata),
    .grd_raddr (grd_raddr),
    .grd_rdata (grd_rdata),
    .chn_we    (chn_we),
    .chn_waddr (chn_waddr),
    .chn_wdata (chn_wdata),
    .chn_raddr (chn_raddr),
    .chn_rdata (chn_rdata)
  );

endmodule

`default_nettype wire

[src/ocrp_checker.sv]
// ----------------------------------------------------------------------------
// ocrp_checker
// Port-level checks of the run planner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ocrp_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [ocrp_pkg::OP_W-1:0]      in_op,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [ocrp_pkg::STATUS_W-1:0]  out_status,
  input wire logic [ocrp_pkg::ID_W-1:0]      out_root_id,
  input wire logic [ocrp_pkg::ID_W-1:0]      out_session_id,
  input wire logic                           out_last
);
  import ocrp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_status, out_root_id, out_session_id, out_last}))
    else $error("result word changed while stalled");

  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FOUND |->
      out_last && out_root_id == '0 && out_session_id == '0)
    else $error("failure word malformed");

  a_root_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FOUND && out_last |-> out_session_id == out_root_id)
    else $error("final run word is not the root");

  a_plan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_PLAN |=> !in_ready)
    else $error("ready right after plan word");

endmodule

bind oldest_complete_run_planner ocrp_checker u_ocrp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_root_id    (out_ch.root_id),
  .out_session_id (out_ch.session_id),
  .out_last       (out_ch.last)
);

`default_nettype wire
